>>> design/periodic_3d_stencil_update_macros.svh
// Assertion macros for the periodic 3D stencil update block.
// Used by the port-level checker; no other dependencies.
`ifndef PERIODIC_3D_STENCIL_UPDATE_MACROS_SVH
`define PERIODIC_3D_STENCIL_UPDATE_MACROS_SVH

// Implication checked on every rising clock edge, off during reset
`define P3S_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%s failed", "label");

// Implication with a fixed delay of given cycles
`define P3S_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("%s failed", "label");

`endif

>>> design/p3s_pkg.sv
// Package for the periodic 3D stencil update block: types, constants, helpers.
// No dependencies.
`default_nettype none
package p3s_pkg;

    localparam int DEF_DIM_I = 16;
    localparam int DEF_DIM_J = 16;
    localparam int DEF_DIM_K = 16;
    localparam int COORD_W   = 4;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ADVECT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_HI = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_LO = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] q_t;

    // Saturated value and clamp flag
    typedef struct packed {
        q_t   val;
        logic hit;
    } sat_t;

    // Clamp a 36-bit signed sum to 32 bits
    function automatic sat_t sat36(input logic signed [35:0] x);
        sat_t r;
        if (x > 36'sd2147483647) begin
            r.val = SAT_HI;
            r.hit = 1'b1;
        end else if (x < -36'sd2147483648) begin
            r.val = SAT_LO;
            r.hit = 1'b1;
        end else begin
            r.val = x[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // Q16.16 product: floor shift by 16 (arithmetic shift), saturate
    function automatic sat_t qscale(input logic signed [63:0] p);
        sat_t r;
        logic signed [47:0] s;
        s = p[63:16];
        if (s > 48'sd2147483647) begin
            r.val = SAT_HI;
            r.hit = 1'b1;
        end else if (s < -48'sd2147483648) begin
            r.val = SAT_LO;
            r.hit = 1'b1;
        end else begin
            r.val = s[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/p3s_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module p3s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> design/periodic_3d_stencil_update.sv
// Periodic 3D seven-point stencil update. An accepted update beat passes stages s1 to s6
// and the output register before its result strobes on done; writes give no result.
// Throughput: one beat per cycle; six grid copies give six neighbor reads a cycle.
// A grid write lands in the RAMs at its accepting edge, so the next beat reads it.
// Reset clears control and coefficients but sets prescale to 1.0 (Q16.16); grid contents are undefined until written.
// The receiver cannot stall, so busy never rises.
`default_nettype none
module periodic_3d_stencil_update
    import p3s_pkg::*;
#(
    parameter int DIM_I = DEF_DIM_I,
    parameter int DIM_J = DEF_DIM_J,
    parameter int DIM_K = DEF_DIM_K
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cmd,
    input  wire logic [COORD_W-1:0]   pos_i,
    input  wire logic [COORD_W-1:0]   pos_j,
    input  wire logic [COORD_W-1:0]   pos_k,
    input  wire logic signed [31:0]   field_value,
    input  wire logic signed [31:0]   u_old,
    input  wire logic signed [31:0]   vel_i,
    input  wire logic signed [31:0]   vel_j,
    input  wire logic signed [31:0]   vel_k,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic                      done,
    output logic signed [31:0]        u_new,
    output logic                      overflow
);

    localparam int IW    = (DIM_I > 1) ? $clog2(DIM_I) : 1;
    localparam int JW    = (DIM_J > 1) ? $clog2(DIM_J) : 1;
    localparam int KW    = (DIM_K > 1) ? $clog2(DIM_K) : 1;
    localparam int DEPTH = DIM_I * DIM_J * DIM_K;
    localparam int AW    = $clog2(DEPTH);
    // Subtractions needed to bring any coordinate below any dimension of at least 3
    localparam int RED_STEPS = ((1 << COORD_W) - 1) / 3;

    // Coefficient registers
    q_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= 32'sd65536;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ADVECT:   c0_reg <= cfg_data;
                REG_PRESCALE: c1_reg <= cfg_data;
                REG_CENTRE:   c2_reg <= cfg_data;
                REG_DIFFUSE:  c3_reg <= cfg_data;
                REG_STEP:     c4_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Coordinate modulo a dimension by repeated compare and subtract
    function automatic logic [7:0] wrap_coord(input logic [COORD_W-1:0] p,
                                              input int dim);
        logic [7:0] x;
        x = 8'(p);
        for (int n = 0; n < RED_STEPS; n++)
        begin
            if (32'(x) >= dim)
            begin
                x = x - 8'(dim);
            end
        end
        return x;
    endfunction

    // Coordinate reduction and neighbor addresses
    logic accept;
    logic [IW-1:0] ci, im, ip;
    logic [JW-1:0] cj, jm, jp;
    logic [KW-1:0] ck, km, kp;
    assign accept = start && !busy;

    always_comb
    begin
        ci = IW'(wrap_coord(pos_i, DIM_I));
        cj = JW'(wrap_coord(pos_j, DIM_J));
        ck = KW'(wrap_coord(pos_k, DIM_K));
        im = (ci == '0) ? IW'(DIM_I - 1) : ci - 1'b1;
        ip = (32'(ci) == DIM_I - 1) ? '0 : ci + 1'b1;
        jm = (cj == '0) ? JW'(DIM_J - 1) : cj - 1'b1;
        jp = (32'(cj) == DIM_J - 1) ? '0 : cj + 1'b1;
        km = (ck == '0) ? KW'(DIM_K - 1) : ck - 1'b1;
        kp = (32'(ck) == DIM_K - 1) ? '0 : ck + 1'b1;
    end

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] a,
                                                input logic [JW-1:0] b,
                                                input logic [KW-1:0] c);
        logic [31:0] t;
        t = (32'(a) * DIM_J + 32'(b)) * DIM_K + 32'(c);
        return t[AW-1:0];
    endfunction

    logic [AW-1:0] rd_addr [6];
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    assign rd_addr[0] = cell_addr(im, cj, ck);
    assign rd_addr[1] = cell_addr(ip, cj, ck);
    assign rd_addr[2] = cell_addr(ci, jm, ck);
    assign rd_addr[3] = cell_addr(ci, jp, ck);
    assign rd_addr[4] = cell_addr(ci, cj, km);
    assign rd_addr[5] = cell_addr(ci, cj, kp);
    assign wr_addr    = cell_addr(ci, cj, ck);
    assign wr_en      = accept && (cmd == CMD_WRITE);

    // Six grid copies, one per neighbor
    q_t rd_data [6];
    genvar g;
    generate
        for (g = 0; g < 6; g++)
        begin : gen_copy
            p3s_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
                .clk     (clk),
                .wr_en   (wr_en),
                .wr_addr (wr_addr),
                .wr_data (field_value),
                .rd_addr (rd_addr[g]),
                .rd_data (rd_data[g])
            );
        end
    endgenerate

    // Stage 1: registered read; one beat per cycle, so a write and a read
    // of the same beat never meet and a write is visible one beat later
    logic          s1_vld_reg;
    q_t            s1_u_reg, s1_vi_reg, s1_vj_reg, s1_vk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept && (cmd == CMD_UPDATE);
        end
    end
    always_ff @(posedge clk)
    begin
        s1_u_reg  <= u_old;
        s1_vi_reg <= vel_i;
        s1_vj_reg <= vel_j;
        s1_vk_reg <= vel_k;
    end
    q_t nb [6];
    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            nb[n] = rd_data[n];
        end
    end

    // Stage 2: prescale product on one neighbor, sum of the other five, neighbor differences
    logic s2_vld_reg;
    logic signed [63:0] s2_n_reg;
    logic signed [35:0] s2_sum5_reg;
    sat_t s2_ei_reg, s2_ej_reg, s2_ek_reg, s2_t_reg;
    q_t   s2_u_reg, s2_vi_reg, s2_vj_reg, s2_vk_reg;
    sat_t t3;
    assign t3 = sat36(36'(c2_reg) * 36'sd3);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_vld_reg <= 1'b0;
        else        s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s2_n_reg    <= 64'(c1_reg) * 64'(nb[0]);
        s2_sum5_reg <= 36'(nb[1]) + 36'(nb[2]) + 36'(nb[3]) + 36'(nb[4]) + 36'(nb[5]);
        s2_ei_reg   <= sat36(36'(nb[1]) - 36'(nb[0]));
        s2_ej_reg   <= sat36(36'(nb[3]) - 36'(nb[2]));
        s2_ek_reg   <= sat36(36'(nb[5]) - 36'(nb[4]));
        s2_t_reg    <= t3;
        s2_u_reg    <= s1_u_reg;
        s2_vi_reg   <= s1_vi_reg;
        s2_vj_reg   <= s1_vj_reg;
        s2_vk_reg   <= s1_vk_reg;
    end

    // Stage 3: neighbor sum, advection products, centre product
    logic s3_vld_reg;
    sat_t s3_s_reg;
    logic signed [63:0] s3_ai_reg, s3_aj_reg, s3_ak_reg, s3_q_reg;
    logic s3_hit_reg;
    q_t   s3_u_reg;
    sat_t n3;
    assign n3 = qscale(s2_n_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else        s3_vld_reg <= s2_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s3_s_reg   <= sat36(36'(n3.val) + s2_sum5_reg);
        s3_ai_reg  <= 64'(s2_ei_reg.val) * 64'(s2_vi_reg);
        s3_aj_reg  <= 64'(s2_ej_reg.val) * 64'(s2_vj_reg);
        s3_ak_reg  <= 64'(s2_ek_reg.val) * 64'(s2_vk_reg);
        s3_q_reg   <= 64'(s2_t_reg.val) * 64'(s2_u_reg);
        s3_hit_reg <= n3.hit | s2_ei_reg.hit | s2_ej_reg.hit | s2_ek_reg.hit
                      | s2_t_reg.hit;
        s3_u_reg   <= s2_u_reg;
    end

    // Stage 4: diffusion product, advection sum
    logic s4_vld_reg;
    logic signed [63:0] s4_d_reg;
    sat_t s4_a_reg, s4_q_reg;
    logic s4_hit_reg;
    q_t   s4_u_reg;
    sat_t pi, pj, pk, pq;
    assign pi = qscale(s3_ai_reg);
    assign pj = qscale(s3_aj_reg);
    assign pk = qscale(s3_ak_reg);
    assign pq = qscale(s3_q_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s4_vld_reg <= 1'b0;
        else        s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s4_d_reg   <= 64'(c3_reg) * 64'(s3_s_reg.val);
        s4_a_reg   <= sat36(36'(pi.val) + 36'(pj.val) + 36'(pk.val));
        s4_q_reg   <= pq;
        s4_hit_reg <= s3_hit_reg | s3_s_reg.hit | pi.hit | pj.hit | pk.hit;
        s4_u_reg   <= s3_u_reg;
    end

    // Stage 5: advection coefficient product
    logic s5_vld_reg;
    sat_t s5_d_reg, s5_q_reg;
    logic signed [63:0] s5_e_reg;
    logic s5_hit_reg;
    q_t   s5_u_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s5_vld_reg <= 1'b0;
        else        s5_vld_reg <= s4_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s5_d_reg   <= qscale(s4_d_reg);
        s5_q_reg   <= s4_q_reg;
        s5_e_reg   <= 64'(c0_reg) * 64'(s4_a_reg.val);
        s5_hit_reg <= s4_hit_reg | s4_a_reg.hit;
        s5_u_reg   <= s4_u_reg;
    end

    // Stage 6: increment g, then step product
    logic s6_vld_reg;
    logic signed [63:0] s6_p_reg;
    logic s6_hit_reg;
    q_t   s6_u_reg;
    sat_t e6, g6;
    assign e6 = qscale(s5_e_reg);
    assign g6 = sat36(36'(s5_d_reg.val) - 36'(s5_q_reg.val) - 36'(e6.val));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s6_vld_reg <= 1'b0;
        else        s6_vld_reg <= s5_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s6_p_reg   <= 64'(c4_reg) * 64'(g6.val);
        s6_hit_reg <= s5_hit_reg | s5_d_reg.hit | s5_q_reg.hit | e6.hit | g6.hit;
        s6_u_reg   <= s5_u_reg;
    end

    // Stage 7: final sum and output register
    sat_t p7, r7;
    logic done_reg;
    q_t   u_new_reg;
    logic ovf_reg;
    assign p7 = qscale(s6_p_reg);
    assign r7 = sat36(36'(s6_u_reg) + 36'(p7.val));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= s6_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        u_new_reg <= r7.val;
        ovf_reg   <= s6_hit_reg | p7.hit | r7.hit;
    end

    assign done     = done_reg;
    assign u_new    = u_new_reg;
    assign overflow = ovf_reg;

endmodule
`default_nettype wire

>>> design/p3s_checker.sv
// Port-level checker for the periodic 3D stencil update block, with bind.
// Depends on p3s_pkg and periodic_3d_stencil_update_macros.svh.
`default_nettype none
`include "periodic_3d_stencil_update_macros.svh"
module p3s_checker
    import p3s_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic cmd,
    input wire logic cfg_ready,
    input wire logic done
);
    // An accepted update produces a result
    `P3S_ASSERT_DLY(a_upd_done, clk, rst_n, start && !busy && cmd == CMD_UPDATE, 7, done)
    // A grid write never produces a result
    `P3S_ASSERT_DLY(a_wr_none, clk, rst_n, start && !busy && cmd == CMD_WRITE, 7, !done)
    // No result without an earlier accepted update
    `P3S_ASSERT_IMP(a_done_src, clk, rst_n, done && $past(rst_n, 7),
        $past(start && !busy && cmd == CMD_UPDATE, 7))
    // Block always ready for configuration and input beats
    `P3S_ASSERT_IMP(a_ready, clk, rst_n, 1'b1, cfg_ready && !busy)
endmodule

bind periodic_3d_stencil_update p3s_checker u_p3s_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
    .cfg_ready(cfg_ready), .done(done)
);
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for periodic_3d_stencil_update: directed table, then random phases.
// Depends on p3s_pkg and the RTL of the block; predicts results with its own grid model.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import p3s_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd5;   // first unmapped index
    localparam int DRAIN_CYCLES = 12;
    localparam int ITEM_TARGET  = 550;
    localparam int PHASES       = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 cmd = CMD_WRITE;
    logic [COORD_W-1:0]   pos_i = '0, pos_j = '0, pos_k = '0;
    logic signed [31:0]   field_value = '0, u_old = '0;
    logic signed [31:0]   vel_i = '0, vel_j = '0, vel_k = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 done;
    logic signed [31:0]   u_new;
    logic                 overflow;

    periodic_3d_stencil_update dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected result of one update beat
    typedef struct {
        q_t   u;
        logic ovf;
    } upd_result_t;

    // One row of the directed table
    typedef struct {
        logic               op;
        logic [3:0]         i, j, k;
        logic signed [31:0] fv, u, vi, vj, vk;
        bit                 typed;
        q_t                 eu;
        logic               eo;
    } stim_row_t;

    upd_result_t pending_updates[$];
    q_t          grid_model[4096];
    bit          grid_written[4096];
    longint      coef[5];
    bit          clamp_seen;
    bit          idle_en = 1'b0;
    int          errors = 0;
    int          n_items = 0;
    int          n_updates = 0;
    int          n_checked = 0;
    int          n_cfg = 0;

    // Grid address, 4-bit coordinates wrap naturally on a 16-cube
    function automatic int cell_addr(logic [3:0] i, logic [3:0] j, logic [3:0] k);
        return {i, j, k};
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) begin
            clamp_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clamp_seen = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Q16.16 product, floor rounding, saturated
    function automatic longint qprod(longint a, longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 16);
    endfunction

    function automatic upd_result_t stencil_update(logic [3:0] i, logic [3:0] j,
            logic [3:0] k, q_t uq, q_t w0, q_t w1, q_t w2);
        upd_result_t r;
        longint vim, vip, vjm, vjp, vkm, vkp, s, d, q, a, e, g;
        clamp_seen = 1'b0;
        vim = grid_model[cell_addr(i - 4'd1, j, k)];
        vip = grid_model[cell_addr(i + 4'd1, j, k)];
        vjm = grid_model[cell_addr(i, j - 4'd1, k)];
        vjp = grid_model[cell_addr(i, j + 4'd1, k)];
        vkm = grid_model[cell_addr(i, j, k - 4'd1)];
        vkp = grid_model[cell_addr(i, j, k + 4'd1)];
        s = clip32(qprod(coef[REG_PRESCALE], vim) + vip + vjm + vjp + vkm + vkp);
        d = qprod(coef[REG_DIFFUSE], s);
        q = qprod(clip32(3 * coef[REG_CENTRE]), uq);
        a = clip32(qprod(clip32(vip - vim), w0) + qprod(clip32(vjp - vjm), w1)
                 + qprod(clip32(vkp - vkm), w2));
        e = qprod(coef[REG_ADVECT], a);
        g = clip32(d - q - e);
        r.u = q_t'(clip32(longint'(uq) + qprod(coef[REG_STEP], g)));
        r.ovf = clamp_seen;
        return r;
    endfunction

    // Random Q16.16 value: extremes, full range or small
    function automatic logic signed [31:0] rand_q();
        int unsigned m;
        m = $urandom_range(0, 7);
        if (m == 0)
            return ($urandom_range(0, 1) != 0) ? SAT_HI : SAT_LO;
        if (m < 4)
            return $urandom;
        return $signed($urandom_range(0, 1048575)) - 524288;
    endfunction

    // Result checker: each clock with done high pops and checks one expected result
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected result: u_new %h overflow %b", u_new, overflow);
                errors++;
            end else begin
                upd_result_t x;
                x = pending_updates.pop_front();
                n_checked++;
                if (u_new !== x.u) begin
                    $error("u_new: expected %h actual %h", x.u, u_new);
                    errors++;
                end
                if (overflow !== x.ovf) begin
                    $error("overflow: expected %b actual %b", x.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    // Drive one beat and hold it until accepted; start stays high afterwards
    task automatic send_beat(stim_row_t r);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= r.op;
        pos_i <= r.i;
        pos_j <= r.j;
        pos_k <= r.k;
        field_value <= r.fv;
        u_old <= r.u;
        vel_i <= r.vi;
        vel_j <= r.vj;
        vel_k <= r.vk;
        @(posedge clk);
        while (busy) @(posedge clk);
        n_items++;
        if (r.op == CMD_WRITE) begin
            grid_model[cell_addr(r.i, r.j, r.k)] = r.fv;
            grid_written[cell_addr(r.i, r.j, r.k)] = 1'b1;
        end else begin
            upd_result_t x;
            n_updates++;
            if (r.typed) begin
                x.u = r.eu;
                x.ovf = r.eo;
            end else
                x = stencil_update(r.i, r.j, r.k, r.u, r.vi, r.vj, r.vk);
            pending_updates.push_back(x);
        end
    endtask

    function automatic stim_row_t grid_write(logic [3:0] i, logic [3:0] j,
            logic [3:0] k, logic signed [31:0] v);
        stim_row_t r;
        r = '{op: CMD_WRITE, i: i, j: j, k: k, fv: v, u: $urandom, vi: $urandom,
              vj: $urandom, vk: $urandom, typed: 1'b0, eu: '0, eo: 1'b0};
        return r;
    endfunction

    function automatic stim_row_t point_update(logic [3:0] i, logic [3:0] j,
            logic [3:0] k, logic signed [31:0] u, logic signed [31:0] w0,
            logic signed [31:0] w1, logic signed [31:0] w2);
        stim_row_t r;
        r = '{op: CMD_UPDATE, i: i, j: j, k: k, fv: $urandom, u: u, vi: w0, vj: w1,
              vk: w2, typed: 1'b0, eu: '0, eo: 1'b0};
        return r;
    endfunction

    // Neighbor write ahead of an update: always when unwritten, sometimes to refresh
    task automatic prep_cell(logic [3:0] i, logic [3:0] j, logic [3:0] k);
        if (!grid_written[cell_addr(i, j, k)] || $urandom_range(0, 4) == 0)
            send_beat(grid_write(i, j, k, rand_q()));
    endtask

    // Register write while idle; cfg_valid is left high for back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        n_cfg++;
        if (idx <= REG_STEP)
            coef[idx] = longint'($signed(val));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_updates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] phase_coef(int ph, int idx);
        case (ph)
            1: return (idx == REG_PRESCALE) ? 32'h0001_0000 : 32'h0000_4000;
            2: return SAT_HI;
            3: return SAT_LO;
            default:
                if ($urandom_range(0, 3) == 0)
                    return $urandom;
                else
                    return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    stim_row_t directed[$];

    initial
    begin
        stim_row_t r;
        logic [3:0] pi, pj, pk;
        for (int n = 0; n < 4096; n++) begin
            grid_model[n] = '0;
            grid_written[n] = 1'b0;
        end
        coef[REG_ADVECT] = 0;
        coef[REG_PRESCALE] = 65536;
        coef[REG_CENTRE] = 0;
        coef[REG_DIFFUSE] = 0;
        coef[REG_STEP] = 0;

        // Neighbors of the origin, wrapping to 15 on each axis
        directed.push_back(grid_write(4'd15, 4'd0, 4'd0, 32'sh0001_0000));
        directed.push_back(grid_write(4'd1, 4'd0, 4'd0, 32'sh0002_0000));
        directed.push_back(grid_write(4'd0, 4'd15, 4'd0, 32'sh0003_0000));
        directed.push_back(grid_write(4'd0, 4'd1, 4'd0, -32'sh0001_0000));
        directed.push_back(grid_write(4'd0, 4'd0, 4'd15, 32'sh0000_0000));
        directed.push_back(grid_write(4'd0, 4'd0, 4'd1, 32'sh0000_8000));
        // Reset coefficients: zero step scale passes u through
        r = point_update(4'd0, 4'd0, 4'd0, SAT_HI, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        r.typed = 1'b1; r.eu = SAT_HI; r.eo = 1'b0;
        directed.push_back(r);
        r = point_update(4'd0, 4'd0, 4'd0, SAT_LO, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        r.typed = 1'b1; r.eu = SAT_LO; r.eo = 1'b0;
        directed.push_back(r);
        // Extreme neighbors: i difference clamps and raises the flag
        directed.push_back(grid_write(4'd1, 4'd0, 4'd0, SAT_HI));
        directed.push_back(grid_write(4'd15, 4'd0, 4'd0, SAT_LO));
        r = point_update(4'd0, 4'd0, 4'd0, 32'sh0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        r.typed = 1'b1; r.eu = '0; r.eo = 1'b1;
        directed.push_back(r);
        // Far corner, wrapping upward to 0
        directed.push_back(grid_write(4'd14, 4'd15, 4'd15, 32'sh0));
        directed.push_back(grid_write(4'd0, 4'd15, 4'd15, 32'sh0));
        directed.push_back(grid_write(4'd15, 4'd14, 4'd15, 32'sh0));
        directed.push_back(grid_write(4'd15, 4'd0, 4'd15, 32'sh0));
        directed.push_back(grid_write(4'd15, 4'd15, 4'd14, 32'sh0));
        directed.push_back(grid_write(4'd15, 4'd15, 4'd0, 32'sh0));
        r = point_update(4'd15, 4'd15, 4'd15, 32'sh1234_5678, SAT_LO, SAT_HI, SAT_LO);
        r.typed = 1'b1; r.eu = 32'sh1234_5678; r.eo = 1'b0;
        directed.push_back(r);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
            send_beat(directed[n]);

        // Random phases, each under a new coefficient set
        for (int ph = 1; ph <= PHASES; ph++) begin
            wait_idle();
            for (int idx = REG_ADVECT; idx <= REG_STEP; idx++)
                write_reg(CFG_IDX_W'(idx), phase_coef(ph, idx));
            if (ph % 3 == 0)
                write_reg(REG_NONE + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
            cfg_valid <= 1'b0;
            idle_en = (ph < PHASES);
            while (n_items < (ITEM_TARGET * ph) / PHASES) begin
                pi = $urandom;
                pj = $urandom;
                pk = $urandom;
                if ($urandom_range(0, 4) == 0) begin
                    // stray write anywhere in the grid
                    send_beat(grid_write(pi, pj, pk, rand_q()));
                end else begin
                    prep_cell(pi - 4'd1, pj, pk);
                    prep_cell(pi + 4'd1, pj, pk);
                    prep_cell(pi, pj - 4'd1, pk);
                    prep_cell(pi, pj + 4'd1, pk);
                    prep_cell(pi, pj, pk - 4'd1);
                    prep_cell(pi, pj, pk + 4'd1);
                    send_beat(point_update(pi, pj, pk, rand_q(), rand_q(), rand_q(),
                                           rand_q()));
                end
            end
        end

        wait_idle();
        $display("Covered %0d beats (%0d updates, %0d results checked), %0d register writes",
                 n_items, n_updates, n_checked, n_cfg);
        $display("over %0d coefficient settings including both saturation extremes.", PHASES + 1);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
